FILE: rtl/dtws_pkg.sv
package dtws_pkg;

    localparam int TUNE_BITS = 32;
    localparam int CTRL_BITS = 8;
    localparam int FREQ_W    = 28;
    localparam int REF_W     = 28;
    localparam int RUN_LEN   = TUNE_BITS + CTRL_BITS + 1;
    localparam int IDX_W     = $clog2(RUN_LEN);
    localparam int STEP_W    = $clog2(TUNE_BITS);

    localparam logic [REF_W-1:0]     REF_RESET       = REF_W'(180000000);
    localparam logic [CTRL_BITS-1:0] CTRL_MULT_ON    = CTRL_BITS'(1);
    localparam logic [CTRL_BITS-1:0] CTRL_POWER_DOWN = CTRL_BITS'(4);

    // one computed request travelling from the divider to the serializer
    typedef struct packed {
        logic [TUNE_BITS-1:0] word;
        logic                 zero;
    } t_job;

    // handshake between a producer and the job queue
    typedef struct packed {
        logic push;
        logic full;
    } t_q_wr;

    // handshake between the job queue and a consumer
    typedef struct packed {
        logic pop;
        logic empty;
    } t_q_rd;

endpackage

FILE: rtl/dtws_freq_if.sv
interface dtws_freq_if;
    logic                         valid;
    logic                         ready;
    logic [dtws_pkg::FREQ_W-1:0]  freq_hz;

    modport source (output valid, output freq_hz, input ready);
    modport sink   (input valid, input freq_hz, output ready);
endinterface

FILE: rtl/dtws_result_if.sv
interface dtws_result_if;
    logic                           valid;
    logic                           ready;
    logic                           data_bit;
    logic                           is_load_pulse;
    logic [dtws_pkg::TUNE_BITS-1:0] tuning_word;
    logic                           last;

    modport source (output valid, output data_bit, output is_load_pulse,
                    output tuning_word, output last, input ready);
    modport sink   (input valid, input data_bit, input is_load_pulse,
                    input tuning_word, input last, output ready);
endinterface

FILE: rtl/dtws_cfg_if.sv
interface dtws_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [dtws_pkg::REF_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/dtws_front.sv
module dtws_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dtws_freq_if.sink                      i_req,
    dtws_cfg_if.sink                       i_cfg,
    input  logic                           i_full,
    output dtws_pkg::t_q_wr                o_wr,
    output dtws_pkg::t_job                 o_job
);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_PUSH} t_state;

    t_state                             r_state, n_state;
    logic [dtws_pkg::REF_W-1:0]         r_ref;
    logic [dtws_pkg::REF_W-1:0]         r_rem, n_rem;
    logic [dtws_pkg::TUNE_BITS-1:0]     r_quo, n_quo;
    logic [dtws_pkg::STEP_W-1:0]        r_cnt, n_cnt;
    logic                               r_sat, n_sat;
    logic                               r_zero, n_zero;

    logic                               accept;
    logic                               push;
    logic [dtws_pkg::REF_W:0]           shifted;
    logic                               ge;

    assign push          = (r_state == ST_PUSH) && !i_full;
    assign i_req.ready   = (r_state == ST_IDLE) || push;
    assign accept        = i_req.valid && i_req.ready;
    assign i_cfg.ready   = 1'b1;

    // one restoring step per cycle, remainder stays below the reference while the frequency is below it
    assign shifted = {r_rem, 1'b0};
    assign ge      = shifted >= {1'b0, r_ref};

    assign o_wr.push = push;
    assign o_wr.full = i_full;
    // zero frequency always gives a zero word, even with a zero reference
    assign o_job.word = r_zero ? '0 : (r_sat ? '1 : r_quo);
    assign o_job.zero = r_zero;

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_sat   = r_sat;
        n_zero  = r_zero;
        unique case (r_state) inside
            ST_IDLE, ST_PUSH: begin
                if (r_state == ST_PUSH && push) begin
                    n_state = ST_IDLE;
                end
                if (accept) begin
                    n_state = ST_DIV;
                    n_rem   = i_req.freq_hz;
                    n_quo   = '0;
                    n_cnt   = '0;
                    n_zero  = (i_req.freq_hz == '0);
                    n_sat   = (i_req.freq_hz != '0) && (i_req.freq_hz >= r_ref);
                end
            end
            ST_DIV: begin
                n_rem = ge ? dtws_pkg::REF_W'(shifted - {1'b0, r_ref})
                           : dtws_pkg::REF_W'(shifted);
                n_quo = {r_quo[dtws_pkg::TUNE_BITS-2:0], ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == dtws_pkg::STEP_W'(dtws_pkg::TUNE_BITS - 1)) begin
                    n_state = ST_PUSH;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ref   <= dtws_pkg::REF_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_ref <= i_cfg.data;
            end
        end
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        r_sat  <= n_sat;
        r_zero <= n_zero;
    end

endmodule

FILE: rtl/dtws_queue.sv
module dtws_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dtws_pkg::t_job   i_job,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output dtws_pkg::t_job   o_job
);

    dtws_pkg::t_job  r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: rtl/dtws_back.sv
module dtws_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dtws_pkg::t_q_rd   i_rd,
    input  dtws_pkg::t_job    i_job,
    output logic              o_pop,
    dtws_result_if.source     o_res
);

    localparam int SH_W = dtws_pkg::TUNE_BITS + dtws_pkg::CTRL_BITS;

    logic                            r_valid;
    logic [SH_W-1:0]                 r_sh;
    logic [dtws_pkg::TUNE_BITS-1:0]  r_word;
    logic [dtws_pkg::IDX_W-1:0]      r_idx;
    logic                            r_last;

    logic                            advance;
    logic                            take_new;

    assign advance  = !r_valid || o_res.ready;
    assign take_new = advance && (!r_valid || r_last);
    assign o_pop    = take_new && !i_rd.empty;

    assign o_res.valid         = r_valid;
    assign o_res.data_bit      = r_last ? 1'b0 : r_sh[0];
    assign o_res.is_load_pulse = r_last;
    assign o_res.tuning_word   = r_word;
    assign o_res.last          = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            r_idx   <= '0;
        end else if (take_new) begin
            r_valid <= !i_rd.empty;
            r_last  <= 1'b0;
            r_idx   <= '0;
        end else if (advance) begin
            r_idx  <= r_idx + 1'b1;
            r_last <= (r_idx == dtws_pkg::IDX_W'(dtws_pkg::RUN_LEN - 2));
        end
        if (o_pop) begin
            r_word <= i_job.word;
            r_sh   <= {(i_job.zero ? dtws_pkg::CTRL_POWER_DOWN : dtws_pkg::CTRL_MULT_ON),
                       i_job.word};
        end else if (advance && !take_new) begin
            r_sh <= r_sh >> 1;
        end
    end

endmodule

FILE: rtl/dds_tuning_word_serializer.sv
// serial tuning-word loader: each request on i_req carries a frequency in hertz and
// turns into 41 results on o_res, the 32-bit phase step floor(freq * 2^32 / ref) lsb
// first, then the control byte lsb first (1 = multiplier on, 4 = power down for a
// zero frequency with a zero word), then one load strobe flagged by is_load_pulse
// and last; a frequency at or above the reference saturates the word to all ones;
// the reference clock is written on i_cfg (reset 180 MHz) and must only be changed
// while the block is idle, which the block itself does not enforce; the divider
// takes one restoring step per quotient bit, then a push state; a two-entry job
// queue decouples it from the serializer, so with a ready sink the sustained rate
// is set by the serial output, and the first bit follows the push and the pop
module dds_tuning_word_serializer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dtws_freq_if.sink      i_req,
    dtws_cfg_if.sink       i_cfg,
    dtws_result_if.source  o_res
);

    // divider to queue
    dtws_pkg::t_q_wr  wr;
    dtws_pkg::t_job   front_job;
    logic             q_full;

    // queue to serializer
    dtws_pkg::t_q_rd  rd;
    dtws_pkg::t_job   back_job;
    logic             q_pop;
    logic             q_empty;

    assign rd.pop   = q_pop;
    assign rd.empty = q_empty;

    // front: takes requests and config, runs the bit-serial divider
    dtws_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cfg   (i_cfg),
        .i_full  (q_full),
        .o_wr    (wr),
        .o_job   (front_job)
    );

    // short job queue so either side can stall independently
    dtws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (wr.push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (rd.pop),
        .o_empty (q_empty),
        .o_job   (back_job)
    );

    // back: shifts out word, control byte and load strobe
    dtws_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd),
        .i_job   (back_job),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );

endmodule

FILE: tb/sv/dds_tuning_word_serializer_tb.sv
module dds_tuning_word_serializer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dtws_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 600;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 17;
    localparam logic [REF_W-1:0] REF_LOW  = REF_W'(1000000);
    localparam logic [REF_W-1:0] REF_HIGH = REF_W'(200000000);
    localparam logic [FREQ_W-1:0] FREQ_TOP = '1;

    // one serial result as it leaves the block
    typedef struct packed {
        logic                 data_bit;
        logic                 is_load_pulse;
        logic [TUNE_BITS-1:0] tuning_word;
        logic                 last;
    } serial_bit_t;

    // receiver ready patterns
    typedef enum int {RX_FLOW, RX_COIN, RX_COMB, RX_STALLS} rx_mode_e;

    // predicts the 41-bit frame of every accepted request and checks the serial stream
    class frame_tracker;
        logic [REF_W-1:0] ref_hz;
        serial_bit_t      frame_bits[$];
        int unsigned      mismatches;

        function new();
            ref_hz     = REF_RESET;
            mismatches = 0;
        endfunction

        function void set_ref(logic [REF_W-1:0] v);
            ref_hz = v;
        endfunction

        // floor(freq * 2^32 / ref), saturating at or above the reference
        function logic [TUNE_BITS-1:0] expected_word(logic [FREQ_W-1:0] f);
            logic [63:0] scaled;
            if (f == '0)
                return '0;
            if (f >= ref_hz)
                return '1;
            scaled = {4'b0, f, 32'b0};
            return TUNE_BITS'(scaled / 64'(ref_hz));
        endfunction

        function void note_freq(logic [FREQ_W-1:0] f);
            logic [TUNE_BITS-1:0] word;
            logic [CTRL_BITS-1:0] ctrl;
            word = expected_word(f);
            ctrl = (f == '0) ? CTRL_POWER_DOWN : CTRL_MULT_ON;
            for (int i = 0; i < TUNE_BITS; i++)
                frame_bits.push_back('{word[i], 1'b0, word, 1'b0});
            for (int i = 0; i < CTRL_BITS; i++)
                frame_bits.push_back('{ctrl[i], 1'b0, word, 1'b0});
            frame_bits.push_back('{1'b0, 1'b1, word, 1'b1});
        endfunction

        function void check_bit(serial_bit_t got);
            serial_bit_t want;
            if (frame_bits.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = frame_bits.pop_front();
            if (got.data_bit !== want.data_bit) begin
                $display("%0t: data_bit expected %b actual %b", $time,
                         want.data_bit, got.data_bit);
                mismatches++;
            end
            if (got.is_load_pulse !== want.is_load_pulse) begin
                $display("%0t: is_load_pulse expected %b actual %b", $time,
                         want.is_load_pulse, got.is_load_pulse);
                mismatches++;
            end
            if (got.tuning_word !== want.tuning_word) begin
                $display("%0t: tuning_word expected %h actual %h", $time,
                         want.tuning_word, got.tuning_word);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return frame_bits.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    dtws_freq_if   req_if();
    dtws_cfg_if    cfg_if();
    dtws_result_if res_if();

    frame_tracker tracker = new();

    bit hold_req  = 1'b0;   // asks the receiver for one long hold-off
    int burst_left = 0;

    dds_tuning_word_serializer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    always #6 i_clk = ~i_clk;

    // result monitor, values sampled as they stood before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            tracker.check_bit('{res_if.data_bit, res_if.is_load_pulse,
                                res_if.tuning_word, res_if.last});
    end

    // receiver: ready pattern switches between modes, plus one long hold-off on demand
    initial begin : receiver
        rx_mode_e    mode;
        int          span;
        int          hold_left;
        int          stall_left;
        int unsigned tick;
        mode       = RX_FLOW;
        span       = 0;
        hold_left  = 0;
        stall_left = 0;
        tick       = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                if (span == 0) begin
                    mode = rx_mode_e'($urandom_range(RX_FLOW, RX_STALLS));
                    span = $urandom_range(30, 300);
                end
                span--;
                case (mode)
                    RX_FLOW: begin
                        res_if.ready <= 1'b1;
                    end
                    RX_COIN: begin
                        res_if.ready <= 1'($urandom_range(0, 1));
                    end
                    RX_COMB: begin
                        res_if.ready <= (tick % 4 != 3);
                    end
                    default: begin
                        if (stall_left == 0 && $urandom_range(0, 9) == 0)
                            stall_left = $urandom_range(1, 12);
                        if (stall_left > 0) begin
                            stall_left--;
                            res_if.ready <= 1'b0;
                        end else begin
                            res_if.ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // offers one request; valid stays high within a burst, drops for a gap after it
    task automatic send_freq(logic [FREQ_W-1:0] f);
        req_if.valid   <= 1'b1;
        req_if.freq_hz <= f;
        do
            @(posedge i_clk);
        while (!(req_if.valid && req_if.ready));
        tracker.note_freq(f);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge i_clk);
            burst_left = $urandom_range(0, 11);
        end
    endtask

    // lowers valid and waits for the block to go idle
    task automatic settle();
        req_if.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ref(logic [REF_W-1:0] v);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do
            @(posedge i_clk);
        while (!(cfg_if.valid && cfg_if.ready));
        cfg_if.valid <= 1'b0;
        tracker.set_ref(v);
    endtask

    function automatic logic [FREQ_W-1:0] pick_freq(logic [REF_W-1:0] r);
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return FREQ_W'($urandom);
            3:       return FREQ_W'(r + $urandom_range(0, 4) - 2);   // around the reference
            4:       return FREQ_W'($urandom_range(1, 1000));
            5, 6:    return FREQ_W'($urandom_range(0, 200000000));
            default: return (r > 1) ? FREQ_W'($urandom_range(1, r - 1)) : FREQ_W'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        logic [REF_W-1:0] ref_now;
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.freq_hz <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.data    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset reference: zero, one, around the reference, field maximum, bit patterns
        send_freq('0);
        send_freq(FREQ_W'(1));
        send_freq(FREQ_W'(179999999));
        send_freq(FREQ_W'(180000000));
        send_freq(FREQ_W'(180000001));
        send_freq(FREQ_TOP);
        send_freq(FREQ_W'('hAAAAAAA));
        send_freq(FREQ_W'('h5555555));
        send_freq(FREQ_W'(100000000));
        settle();

        write_ref(REF_LOW);
        send_freq(FREQ_W'(999999));
        send_freq(FREQ_W'(1000000));
        send_freq(FREQ_W'(1));
        settle();

        write_ref(REF_HIGH);
        send_freq(FREQ_W'(199999999));
        send_freq(FREQ_W'(200000000));
        send_freq('0);
        settle();

        // zero reference saturates any nonzero frequency
        write_ref('0);
        send_freq('0);
        send_freq(FREQ_W'(1));
        send_freq(FREQ_TOP);
        settle();

        // reference beyond its stated range is used as given
        write_ref('1);
        send_freq(FREQ_TOP - 1);
        send_freq(FREQ_TOP);
        send_freq(FREQ_W'(1));
        settle();

        write_ref(REF_W'(1));
        send_freq(FREQ_W'(1));
        send_freq('0);
        settle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                1:       ref_now = REF_LOW;
                3:       ref_now = REF_HIGH;
                6:       ref_now = REF_W'($urandom);
                default: ref_now = REF_W'($urandom_range(1000000, 200000000));
            endcase
            write_ref(ref_now);
            // long receiver hold-off while requests keep coming, fills the job queue
            if (p == 0)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_freq(pick_freq(ref_now));
            settle();
        end

        if (tracker.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: dds_tuning_word_serializer.f
rtl/dtws_pkg.sv
rtl/dtws_freq_if.sv
rtl/dtws_result_if.sv
rtl/dtws_cfg_if.sv
rtl/dtws_front.sv
rtl/dtws_queue.sv
rtl/dtws_back.sv
rtl/dds_tuning_word_serializer.sv
tb/sv/dds_tuning_word_serializer_tb.sv
